FILE: rtl/qnb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package qnb_pkg;

  localparam int BONE_LIMIT     = 128;
  localparam int FULL_BLEND_MIN = 65471;
  localparam int NEG_BLEND_MAX  = 65;
  localparam int ONE_Q16        = 65536;
  localparam int MIN_LEN        = 256;

  localparam int COMP_W     = 16;
  localparam int BLEND_W    = 17;
  localparam int PROD_W     = 32;
  localparam int DOT_W      = 34;
  localparam int MIX_W      = 34;
  localparam int NORM_W     = 25;
  localparam int SQ_W       = 47;
  localparam int RAD_W      = 49;
  localparam int ROOT_W     = 25;
  localparam int NUM_W      = 40;
  localparam int Q_W        = 16;
  localparam int SQRT_STEPS = 25;
  localparam int DIV_STEPS  = 16;

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [NORM_W-1:0] norm_t;

  typedef enum logic [1:0] {
    ACT_KEEP  = 2'd0,
    ACT_COPY  = 2'd1,
    ACT_BLEND = 2'd2
  } action_t;

  typedef struct packed {
    comp_t                current_x;
    comp_t                current_y;
    comp_t                current_z;
    comp_t                current_w;
    comp_t                target_x;
    comp_t                target_y;
    comp_t                target_z;
    comp_t                target_w;
    logic [BLEND_W-1:0]   blend;
    logic                 apply_enable;
    logic [7:0]           bone_index;
  } in_item_t;

  typedef struct packed {
    comp_t   result_x;
    comp_t   result_y;
    comp_t   result_z;
    comp_t   result_w;
    action_t action;
  } out_item_t;

  // What travels alongside the square root: the action, the fallback value and the mix.
  typedef struct packed {
    action_t         kind;
    comp_t [3:0]     fb;
    norm_t [3:0]     n;
  } side_t;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] res;
  } root_acc_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [Q_W-1:0]   q;
  } quo_acc_t;

  // One digit of the bitwise integer square root, from the top pair down.
  function automatic root_acc_t root_step(root_acc_t a, int unsigned k);
    logic [RAD_W:0] bitv;
    logic [RAD_W:0] t;
    root_acc_t      r;
    bitv = (RAD_W+1)'(1) << (RAD_W - 1 - 2 * k);
    t    = {1'b0, a.res} + bitv;
    if ({1'b0, a.rem} >= t) begin
      r.rem = a.rem - t[RAD_W-1:0];
      r.res = (a.res >> 1) + bitv[RAD_W-1:0];
    end else begin
      r.rem = a.rem;
      r.res = a.res >> 1;
    end
    return r;
  endfunction

  // One quotient bit of a restoring division.
  function automatic quo_acc_t div_step(quo_acc_t a, logic [ROOT_W-1:0] den,
                                        int unsigned k);
    logic [NUM_W-1:0] dk;
    quo_acc_t         r;
    dk = NUM_W'(den) << k;
    r  = a;
    if (a.rem >= dk) begin
      r.rem = a.rem - dk;
      r.q   = a.q | (Q_W'(1) << k);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/qnb_isqrt.sv
`timescale 1ns / 1ps
`default_nettype none

module qnb_isqrt import qnb_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [RAD_W-1:0] in_radicand,
  input  wire side_t            in_side,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [ROOT_W-1:0]     out_root,
  output side_t                 out_side
);

  logic [SQRT_STEPS-1:0] sv;
  logic [SQRT_STEPS-1:0] sr;
  root_acc_t             acc  [SQRT_STEPS];
  side_t                 side [SQRT_STEPS];
  root_acc_t             seed;

  // A stage takes a new item when it is empty or the stage after it moves.
  always_comb begin
    logic nxt;
    nxt = out_ready;
    for (int j = SQRT_STEPS - 1; j >= 0; j--) begin
      sr[j] = !sv[j] || nxt;
      nxt   = sr[j];
    end
  end

  assign in_ready  = sr[0];
  assign seed.rem  = in_radicand;
  assign seed.res  = '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      sv <= '0;
    end else begin
      if (sr[0]) begin
        sv[0] <= in_valid;
      end
      for (int j = 1; j < SQRT_STEPS; j++) begin
        if (sr[j]) begin
          sv[j] <= sv[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sr[0]) begin
      acc[0]  <= root_step(seed, 0);
      side[0] <= in_side;
    end
    for (int j = 1; j < SQRT_STEPS; j++) begin
      if (sr[j]) begin
        acc[j]  <= root_step(acc[j-1], j);
        side[j] <= side[j-1];
      end
    end
  end

  assign out_valid = sv[SQRT_STEPS-1];
  assign out_root  = acc[SQRT_STEPS-1].res[ROOT_W-1:0];
  assign out_side  = side[SQRT_STEPS-1];

endmodule

`default_nettype wire

FILE: rtl/quaternion_nlerp_blend.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Handshake                Payload
// in        in_valid / in_ready      in_data  (in_item_t)
// out       out_valid / out_ready    out_data (out_item_t)
//
// One item enters per cycle unless a stalled output has filled every stage.
// The square root has 25 digits and the divider 16 bits, both unrolled
// into one register stage per digit.
// Synchronous reset empties every stage; no payload register is cleared.
// A stalled output holds its result, and empty stages still fill behind it.

module quaternion_nlerp_blend import qnb_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_item_t     out_data
);

  typedef struct packed {
    action_t          kind;
    comp_t [3:0]      fb;
    logic [3:0]       neg;
    logic [ROOT_W-1:0] den;
    quo_acc_t [3:0]   acc;
  } div_stage_t;

  // Front stages.
  logic [5:0]          fv;
  logic [5:0]          fr;
  comp_t               s1_cur [4];
  comp_t               s1_tgt [4];
  logic [BLEND_W-1:0]  s1_blend;
  action_t             s1_kind;
  logic signed [PROD_W-1:0] s1_prod [4];
  comp_t               s2_cur [4];
  comp_t               s2_tgt [4];
  logic [BLEND_W-1:0]  s2_blend;
  action_t             s2_kind;
  logic                s2_neg;
  comp_t               s3_fb [4];
  action_t             s3_kind;
  logic signed [MIX_W-1:0] s3_pa [4];
  logic signed [MIX_W-1:0] s3_pb [4];
  logic                s3_neg;
  comp_t               s4_fb [4];
  action_t             s4_kind;
  norm_t               s4_n [4];
  comp_t               s5_fb [4];
  action_t             s5_kind;
  norm_t               s5_n [4];
  logic [SQ_W-1:0]     s5_sq [4];
  side_t               s6_side;
  logic [RAD_W-1:0]    s6_sum;

  comp_t               in_cur [4];
  comp_t               in_tgt [4];
  action_t             in_kind;
  logic signed [DOT_W-1:0] dot;
  logic [BLEND_W-1:0]  wc;
  norm_t               mix_n [4];

  logic                root_valid;
  logic                root_ready;
  logic [ROOT_W-1:0]   root;
  side_t               root_side;

  logic [DIV_STEPS:0]  dv;
  logic [DIV_STEPS:0]  dr;
  div_stage_t          ds [DIV_STEPS+1];
  div_stage_t          prep;
  logic                o_ready;
  out_item_t           result;

  assign in_cur[0] = in_data.current_x;
  assign in_cur[1] = in_data.current_y;
  assign in_cur[2] = in_data.current_z;
  assign in_cur[3] = in_data.current_w;
  assign in_tgt[0] = in_data.target_x;
  assign in_tgt[1] = in_data.target_y;
  assign in_tgt[2] = in_data.target_z;
  assign in_tgt[3] = in_data.target_w;

  always_comb begin
    if (!in_data.apply_enable || ({1'b0, in_data.bone_index} >= 9'(BONE_LIMIT))) begin
      in_kind = ACT_KEEP;
    end else if (in_data.blend >= BLEND_W'(FULL_BLEND_MIN)) begin
      in_kind = ACT_COPY;
    end else if (in_data.blend > BLEND_W'(NEG_BLEND_MAX)) begin
      in_kind = ACT_BLEND;
    end else begin
      in_kind = ACT_KEEP;
    end
  end

  assign dot = DOT_W'(s1_prod[0]) + DOT_W'(s1_prod[1])
             + DOT_W'(s1_prod[2]) + DOT_W'(s1_prod[3]);
  assign wc  = BLEND_W'(ONE_Q16) - s2_blend;

  // Mix reduced from scale 2^31 to 2^23, rounding half away from zero.
  always_comb begin
    logic signed [MIX_W:0] m;
    logic [MIX_W:0]        mag;
    logic [MIX_W:0]        rnd;
    for (int i = 0; i < 4; i++) begin
      m   = s3_neg ? ((MIX_W+1)'(s3_pa[i]) - (MIX_W+1)'(s3_pb[i]))
                   : ((MIX_W+1)'(s3_pa[i]) + (MIX_W+1)'(s3_pb[i]));
      mag = m[MIX_W] ? (MIX_W+1)'(-m) : m;
      rnd = (mag + (MIX_W+1)'(128)) >> 8;
      mix_n[i] = m[MIX_W] ? -$signed({1'b0, rnd[NORM_W-2:0]})
                          : $signed({1'b0, rnd[NORM_W-2:0]});
    end
  end

  // Front stage handshake.
  always_comb begin
    logic nxt;
    nxt = root_ready;
    for (int j = 5; j >= 0; j--) begin
      fr[j] = !fv[j] || nxt;
      nxt   = fr[j];
    end
  end

  assign in_ready = fr[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= '0;
    end else begin
      if (fr[0]) begin
        fv[0] <= in_valid;
      end
      for (int j = 1; j < 6; j++) begin
        if (fr[j]) begin
          fv[j] <= fv[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fr[0]) begin
      for (int i = 0; i < 4; i++) begin
        s1_cur[i]  <= in_cur[i];
        s1_tgt[i]  <= in_tgt[i];
        s1_prod[i] <= in_cur[i] * in_tgt[i];
      end
      s1_blend <= in_data.blend;
      s1_kind  <= in_kind;
    end
    if (fr[1]) begin
      s2_cur   <= s1_cur;
      s2_tgt   <= s1_tgt;
      s2_blend <= s1_blend;
      s2_kind  <= s1_kind;
      s2_neg   <= dot[DOT_W-1];
    end
    if (fr[2]) begin
      for (int i = 0; i < 4; i++) begin
        s3_fb[i] <= (s2_kind == ACT_COPY) ? s2_tgt[i] : s2_cur[i];
        s3_pa[i] <= s2_cur[i] * $signed({1'b0, wc});
        s3_pb[i] <= s2_tgt[i] * $signed({1'b0, s2_blend});
      end
      s3_kind <= s2_kind;
      s3_neg  <= s2_neg;
    end
    if (fr[3]) begin
      s4_fb   <= s3_fb;
      s4_kind <= s3_kind;
      s4_n    <= mix_n;
    end
    if (fr[4]) begin
      for (int i = 0; i < 4; i++) begin
        s5_sq[i] <= SQ_W'(s4_n[i] * s4_n[i]);
      end
      s5_fb   <= s4_fb;
      s5_kind <= s4_kind;
      s5_n    <= s4_n;
    end
    if (fr[5]) begin
      s6_sum <= RAD_W'(s5_sq[0]) + RAD_W'(s5_sq[1])
              + RAD_W'(s5_sq[2]) + RAD_W'(s5_sq[3]);
      s6_side.kind <= s5_kind;
      for (int i = 0; i < 4; i++) begin
        s6_side.fb[i] <= s5_fb[i];
        s6_side.n[i]  <= s5_n[i];
      end
    end
  end

  qnb_isqrt u_isqrt (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (fv[5]),
    .in_ready    (root_ready),
    .in_radicand (s6_sum),
    .in_side     (s6_side),
    .out_valid   (root_valid),
    .out_ready   (dr[0]),
    .out_root    (root),
    .out_side    (root_side)
  );

  // Numerator gets half the length added so that the quotient rounds.
  always_comb begin
    logic [NORM_W-1:0] mag;
    prep.kind = root_side.kind;
    if ((root_side.kind == ACT_BLEND) && (root < ROOT_W'(MIN_LEN))) begin
      prep.kind = ACT_KEEP;
    end
    prep.fb  = root_side.fb;
    prep.den = root;
    for (int i = 0; i < 4; i++) begin
      prep.neg[i] = root_side.n[i][NORM_W-1];
      mag = prep.neg[i] ? NORM_W'(-root_side.n[i]) : root_side.n[i];
      prep.acc[i].rem = {mag[NORM_W-2:0], 15'b0} + NUM_W'(root >> 1);
      prep.acc[i].q   = '0;
    end
  end

  assign o_ready = !out_valid || out_ready;

  always_comb begin
    logic nxt;
    nxt = o_ready;
    for (int j = DIV_STEPS; j >= 0; j--) begin
      dr[j] = !dv[j] || nxt;
      nxt   = dr[j];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv        <= '0;
      out_valid <= 1'b0;
    end else begin
      if (dr[0]) begin
        dv[0] <= root_valid;
      end
      for (int j = 1; j <= DIV_STEPS; j++) begin
        if (dr[j]) begin
          dv[j] <= dv[j-1];
        end
      end
      if (o_ready) begin
        out_valid <= dv[DIV_STEPS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dr[0]) begin
      ds[0] <= prep;
    end
    for (int j = 1; j <= DIV_STEPS; j++) begin
      if (dr[j]) begin
        ds[j].kind <= ds[j-1].kind;
        ds[j].fb   <= ds[j-1].fb;
        ds[j].neg  <= ds[j-1].neg;
        ds[j].den  <= ds[j-1].den;
        for (int i = 0; i < 4; i++) begin
          ds[j].acc[i] <= div_step(ds[j-1].acc[i], ds[j-1].den, DIV_STEPS - j);
        end
      end
    end
    if (o_ready) begin
      out_data <= result;
    end
  end

  always_comb begin
    comp_t            r [4];
    logic [Q_W-1:0]   q;
    logic [Q_W:0]     negq;
    for (int i = 0; i < 4; i++) begin
      q    = ds[DIV_STEPS].acc[i].q;
      negq = (Q_W+1)'(0) - {1'b0, q};
      if (ds[DIV_STEPS].kind != ACT_BLEND) begin
        r[i] = ds[DIV_STEPS].fb[i];
      end else if (ds[DIV_STEPS].neg[i]) begin
        r[i] = (q > Q_W'(32768)) ? 16'sh8000 : $signed(negq[COMP_W-1:0]);
      end else begin
        r[i] = (q > Q_W'(32767)) ? 16'sh7fff : $signed(q[COMP_W-1:0]);
      end
    end
    result.result_x = r[0];
    result.result_y = r[1];
    result.result_z = r[2];
    result.result_w = r[3];
    result.action   = ds[DIV_STEPS].kind;
  end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import qnb_pkg::*;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  out_item_t pose_queue[$];
  int        error_count = 0;
  int        idle_cycles = 0;
  bit        done_sending;

  localparam int WATCHDOG_LIMIT = 2000;

  quaternion_nlerp_blend dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_div256(longint v);
    longint mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + 128) >>> 8;
    return (v < 0) ? -mag : mag;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r;
    longint b;
    r = 0;
    b = longint'(1) << 62;
    while (b > v) b = b >>> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >>> 1) + b;
      end else begin
        r = r >>> 1;
      end
      b = b >>> 2;
    end
    return r;
  endfunction

  function automatic comp_t normalize_comp(longint n, longint len);
    longint mag;
    longint q;
    mag = (n < 0) ? -n : n;
    q = (mag * 32768 + len / 2) / len;
    if (n < 0) return (q > 32768) ? comp_t'(-32768) : comp_t'(-q);
    return (q > 32767) ? comp_t'(32767) : comp_t'(q);
  endfunction

  function automatic out_item_t predict_pose(in_item_t it);
    out_item_t r;
    longint cur[4];
    longint tgt[4];
    longint nrm[4];
    longint dot;
    longint s;
    longint wc;
    longint sum;
    longint len;
    longint b;
    cur[0] = it.current_x; cur[1] = it.current_y;
    cur[2] = it.current_z; cur[3] = it.current_w;
    tgt[0] = it.target_x; tgt[1] = it.target_y;
    tgt[2] = it.target_z; tgt[3] = it.target_w;
    b = it.blend;
    r.result_x = it.current_x; r.result_y = it.current_y;
    r.result_z = it.current_z; r.result_w = it.current_w;
    r.action = ACT_KEEP;
    if (it.apply_enable && it.bone_index < BONE_LIMIT) begin
      if (b >= FULL_BLEND_MIN) begin
        r.result_x = it.target_x; r.result_y = it.target_y;
        r.result_z = it.target_z; r.result_w = it.target_w;
        r.action = ACT_COPY;
      end else if (b > NEG_BLEND_MAX) begin
        dot = 0;
        for (int i = 0; i < 4; i++) dot += cur[i] * tgt[i];
        s = (dot < 0) ? -b : b;
        wc = ONE_Q16 - b;
        sum = 0;
        for (int i = 0; i < 4; i++) begin
          nrm[i] = round_div256(cur[i] * wc + tgt[i] * s);
          sum += nrm[i] * nrm[i];
        end
        len = floor_sqrt(sum);
        if (len >= MIN_LEN) begin
          r.result_x = normalize_comp(nrm[0], len);
          r.result_y = normalize_comp(nrm[1], len);
          r.result_z = normalize_comp(nrm[2], len);
          r.result_w = normalize_comp(nrm[3], len);
          r.action = ACT_BLEND;
        end
      end
    end
    return r;
  endfunction

  // Sends one item, with a random gap before it now and then to form bursts.
  int burst_left;
  task automatic send_joint(in_item_t it);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= it;
    pose_queue.push_back(predict_pose(it));
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 5))
      0: return comp_t'(-32768);
      1: return comp_t'(32767);
      2: return comp_t'($urandom_range(0, 15)) - comp_t'(8);
      default: return comp_t'($urandom);
    endcase
  endfunction

  function automatic in_item_t rand_joint(int unsigned bl);
    in_item_t it;
    it.current_x = rand_comp(); it.current_y = rand_comp();
    it.current_z = rand_comp(); it.current_w = rand_comp();
    it.target_x = rand_comp(); it.target_y = rand_comp();
    it.target_z = rand_comp(); it.target_w = rand_comp();
    it.blend = BLEND_W'(bl);
    it.apply_enable = ($urandom_range(0, 9) != 0);
    it.bone_index = ($urandom_range(0, 4) != 0) ? 8'($urandom_range(0, 127))
                                                 : 8'($urandom_range(0, 255));
    return it;
  endfunction

  function automatic in_item_t make_joint(int cx, int cy, int cz, int cw,
                                          int tx, int ty, int tz, int tw,
                                          int bl, bit en, int bone);
    in_item_t it;
    it.current_x = comp_t'(cx); it.current_y = comp_t'(cy);
    it.current_z = comp_t'(cz); it.current_w = comp_t'(cw);
    it.target_x = comp_t'(tx); it.target_y = comp_t'(ty);
    it.target_z = comp_t'(tz); it.target_w = comp_t'(tw);
    it.blend = BLEND_W'(bl); it.apply_enable = en; it.bone_index = 8'(bone);
    return it;
  endfunction

  task automatic test_directed();
    send_joint(make_joint(32767, 0, 0, 0, 0, 32767, 0, 0, 32768, 1, 0));
    send_joint(make_joint(-32768, -32768, -32768, -32768,
                          32767, 32767, 32767, 32767, 32768, 1, 127));
    // Opposite hemispheres: the target is negated before the mix.
    send_joint(make_joint(0, 0, 0, 32767, 0, 0, 0, -32768, 20000, 1, 5));
    send_joint(make_joint(1, 2, 3, 4, 100, 200, 300, 400, 65471, 1, 1));
    send_joint(make_joint(1, 2, 3, 4, 100, 200, 300, 400, 65470, 1, 1));
    send_joint(make_joint(1, 2, 3, 4, 100, 200, 300, 400, 65536, 1, 1));
    send_joint(make_joint(1, 2, 3, 4, 100, 200, 300, 400, 131071, 1, 1));
    send_joint(make_joint(9000, 2, 3, 4, 100, 200, 300, 400, 65, 1, 1));
    send_joint(make_joint(9000, 2, 3, 4, 100, 200, 300, 400, 66, 1, 1));
    send_joint(make_joint(9000, 2, 3, 4, 100, 200, 300, 400, 0, 1, 1));
    send_joint(make_joint(9000, 2, 3, 4, 100, 200, 300, 400, 30000, 0, 1));
    send_joint(make_joint(9000, 2, 3, 4, 100, 200, 300, 400, 30000, 1, 128));
    send_joint(make_joint(9000, 2, 3, 4, 100, 200, 300, 400, 30000, 1, 255));
    // A mix too short to normalize keeps the current value.
    send_joint(make_joint(0, 0, 0, 0, 0, 0, 0, 0, 30000, 1, 2));
    send_joint(make_joint(1, 0, 0, 0, -1, 0, 0, 0, 32768, 1, 2));
    send_joint(make_joint(0, 0, 0, 1, 0, 0, 0, 1, 40000, 1, 2));
    send_joint(make_joint(0, 0, 0, 200, 0, 0, 0, 300, 40000, 1, 2));
    send_joint(make_joint(23170, 0, 0, 23170, -23170, 0, 0, 23170, 32768, 1, 3));
    send_joint(make_joint(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767,
                          100, 1, 4));
  endtask

  task automatic test_random_blends();
    int unsigned bl;
    for (int n = 0; n < 1900; n++) begin
      case ($urandom_range(0, 9))
        0: bl = $urandom_range(0, 65);
        1: bl = $urandom_range(65471, 131071);
        2: bl = $urandom_range(60, 72);
        3: bl = $urandom_range(65465, 65475);
        default: bl = $urandom_range(66, 65470);
      endcase
      send_joint(rand_joint(bl));
    end
  endtask

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      error_count++;
    end
  endtask

  // Receiver stalls in a pattern: periodic runs mixed with random stalls.
  int unsigned stall_phase;
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[9:8] == 2'd0) out_ready <= 1'b1;
      else if (stall_phase[9:8] == 2'd1) out_ready <= (stall_phase[2:0] != 3'd5);
      else out_ready <= ($urandom_range(0, 3) != 0);
    end
  end

  out_item_t exp_pose;
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pose_queue.size() == 0) begin
        $error("result with no item pending");
        error_count++;
      end else begin
        exp_pose = pose_queue.pop_front();
        check_field("result_x", exp_pose.result_x, out_data.result_x);
        check_field("result_y", exp_pose.result_y, out_data.result_y);
        check_field("result_z", exp_pose.result_z, out_data.result_z);
        check_field("result_w", exp_pose.result_w, out_data.result_w);
        check_field("action", exp_pose.action, out_data.action);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_LIMIT && !done_sending) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    burst_left = 0;
    done_sending = 1'b0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_blends();
    in_valid <= 1'b0;
    done_sending = 1'b1;
    while (pose_queue.size() != 0 && idle_cycles <= WATCHDOG_LIMIT) @(posedge clk);
    if (pose_queue.size() != 0) begin
      $display("CHECK FAILED");
      $finish;
    end
    repeat (100) @(posedge clk);
    if (error_count == 0 && pose_queue.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/qnb_pkg.sv
rtl/qnb_isqrt.sv
rtl/quaternion_nlerp_blend.sv
verif/testbench.sv
